FILE: hw/rtl/dsfc_pkg.sv
// Shared types and constants for the digit shape feature classifier.
// No dependencies; dsfc_scan, dsfc_accum and the top level import this package.
`timescale 1ns / 1ps

package dsfc_pkg;

  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned AddrW     = $clog2(MaxWidth);
  localparam int unsigned DimW      = 9;
  localparam int unsigned PixW      = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 9;

  localparam logic [DimW-1:0] MaxWidthDim  = DimW'(MaxWidth);
  localparam logic [DimW-1:0] MaxHeightDim = DimW'(MaxHeight);

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegImageWidth   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegEdgeThresh   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSymTolerance = 2'd3;

  // Reset values of the registers
  localparam logic [DimW-1:0] ResetWidth   = 9'd28;
  localparam logic [DimW-1:0] ResetHeight  = 9'd28;
  localparam logic [PixW-1:0] ResetEdgeThr = 8'd30;
  localparam logic [PixW-1:0] ResetSymTol  = 8'd20;

  // Decision rule limits
  localparam logic [17:0] EdgeFew    = 18'd50;
  localparam logic [16:0] CornerFew  = 17'd10;
  localparam logic [17:0] EdgeMany   = 18'd200;
  localparam logic [16:0] CornerMany = 17'd30;

  // Labels and confidences
  localparam logic signed [4:0] LabelOne   = 5'sd1;
  localparam logic signed [4:0] LabelEight = 5'sd8;
  localparam logic signed [4:0] LabelZero  = 5'sd0;
  localparam logic signed [4:0] LabelNone  = -5'sd1;
  localparam logic [3:0] ConfFewShape  = 4'd6;
  localparam logic [3:0] ConfBusy      = 4'd7;
  localparam logic [3:0] ConfWide      = 4'd5;
  localparam logic [3:0] ConfSymmetric = 4'd6;
  localparam logic [3:0] ConfNone      = 4'd0;

  // One pixel word as handed from the scan stage to the accumulator
  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic [PixW-1:0] above;      // line buffer entry at this column
    logic [PixW-1:0] mirror_px;  // earlier pixel of this row at the mirrored column
    logic            interior;   // row >= 2 and column >= 2
    logic            mirror_chk; // mirrored pair is compared
    logic            last;       // last pixel of the frame
  } dsfc_item_t;

endpackage

FILE: hw/rtl/dsfc_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dsfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: hw/rtl/dsfc_scan.sv
// Raster position counters, line buffer addressing and the input register.
// Depends on dsfc_pkg.
`timescale 1ns / 1ps

module dsfc_scan (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [dsfc_pkg::DimW-1:0]  width_i,
  input  logic [dsfc_pkg::DimW-1:0]  height_i,
  input  logic                       frame_clr_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [dsfc_pkg::PixW-1:0]  pixel_i,
  input  logic                       advance_i,
  output logic                       item_valid_o,
  output dsfc_pkg::dsfc_item_t       item_o,
  output logic                       ram_we_o,
  output logic [dsfc_pkg::AddrW-1:0] ram_waddr_o,
  output logic [dsfc_pkg::PixW-1:0]  ram_wdata_o,
  output logic                       ram_re_o,
  output logic [dsfc_pkg::AddrW-1:0] ram_raddr_a_o,
  output logic [dsfc_pkg::AddrW-1:0] ram_raddr_b_o,
  input  logic [dsfc_pkg::PixW-1:0]  ram_rdata_a_i,
  input  logic [dsfc_pkg::PixW-1:0]  ram_rdata_b_i
);
  import dsfc_pkg::*;

  logic [AddrW-1:0] col_q, col_d;
  logic [AddrW-1:0] row_q, row_d;
  logic             valid_q;
  logic [PixW-1:0]  pixel_q;
  logic [AddrW-1:0] wcol_q;
  logic             interior_q, mirror_chk_q, last_q;
  logic             fwd_a_q, fwd_b_q;
  logic [PixW-1:0]  fwd_px_q;

  logic             accept;
  logic             last_col, last_row;
  logic [DimW-1:0]  mirror;
  logic             mirror_chk;

  assign in_ready_o = !valid_q || advance_i;
  assign accept     = in_valid_i && in_ready_o;

  assign last_col   = ({1'b0, col_q} + DimW'(1)) == width_i;
  assign last_row   = ({1'b0, row_q} + DimW'(1)) == height_i;
  assign mirror     = width_i - DimW'(1) - {1'b0, col_q};
  assign mirror_chk = mirror < {1'b0, width_i[DimW-1:1]};

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + AddrW'(1);
      end else begin
        col_d = col_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      col_q   <= frame_clr_i ? '0 : col_d;
      row_q   <= frame_clr_i ? '0 : row_d;
      if (accept) begin
        valid_q <= 1'b1;
      end else if (advance_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Payload of the input register; forward the word being written when
  // the read hits the same entry in the same cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pixel_q      <= pixel_i;
      wcol_q       <= col_q;
      interior_q   <= (row_q >= AddrW'(2)) && (col_q >= AddrW'(2));
      mirror_chk_q <= mirror_chk;
      last_q       <= last_col && last_row;
      fwd_a_q      <= advance_i && (wcol_q == col_q);
      fwd_b_q      <= advance_i && (wcol_q == mirror[AddrW-1:0]);
      fwd_px_q     <= pixel_q;
    end
  end

  assign ram_re_o      = accept;
  assign ram_raddr_a_o = col_q;
  assign ram_raddr_b_o = mirror[AddrW-1:0];
  assign ram_we_o      = advance_i;
  assign ram_waddr_o   = wcol_q;
  assign ram_wdata_o   = pixel_q;

  assign item_valid_o     = valid_q;
  assign item_o.pixel     = pixel_q;
  assign item_o.above     = fwd_a_q ? fwd_px_q : ram_rdata_a_i;
  assign item_o.mirror_px = fwd_b_q ? fwd_px_q : ram_rdata_b_i;
  assign item_o.interior  = interior_q;
  assign item_o.mirror_chk = mirror_chk_q;
  assign item_o.last      = last_q;

endmodule

FILE: hw/rtl/dsfc_accum.sv
// Edge, corner and symmetry totals, the decision rules and the result register.
// Depends on dsfc_pkg.
`timescale 1ns / 1ps

module dsfc_accum (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [dsfc_pkg::DimW-1:0] width_i,
  input  logic [dsfc_pkg::DimW-1:0] height_i,
  input  logic [dsfc_pkg::PixW-1:0] edge_thr_i,
  input  logic [dsfc_pkg::PixW-1:0] sym_tol_i,
  input  logic                      frame_clr_i,
  input  logic                      item_valid_i,
  input  dsfc_pkg::dsfc_item_t      item_i,
  output logic                      advance_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [4:0]         label_o,
  output logic [3:0]                confidence_tenths_o,
  output logic [17:0]               edge_count_o,
  output logic [16:0]               corner_count_o,
  output logic [15:0]               symmetry_matches_o,
  output logic [15:0]               pairs_checked_o
);
  import dsfc_pkg::*;

  function automatic logic [PixW-1:0] absdiff(logic [PixW-1:0] a, logic [PixW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  logic [PixW-1:0] upper_left_q, left_q;
  logic [17:0]     edge_q, edge_d;
  logic [16:0]     corner_q, corner_d;
  logic [15:0]     match_q, match_d;
  logic [15:0]     pair_q, pair_d;
  logic            out_valid_q;
  logic signed [4:0] label_q, label_d;
  logic [3:0]      conf_q, conf_d;
  logic [17:0]     edge_out_q;
  logic [16:0]     corner_out_q;
  logic [15:0]     match_out_q, pair_out_q;

  logic            edge_h, edge_v, corner_hit, match_hit;
  logic [11:0]     width_x5, height_x6;

  assign advance_o = item_valid_i && (!item_i.last || !out_valid_q || out_ready_i);

  assign edge_v     = item_i.interior && (absdiff(upper_left_q, item_i.above) > edge_thr_i);
  assign edge_h     = item_i.interior && (absdiff(upper_left_q, left_q) > edge_thr_i);
  assign corner_hit = (edge_v || edge_h) && (absdiff(upper_left_q, item_i.pixel) > edge_thr_i);
  assign match_hit  = item_i.mirror_chk && (absdiff(item_i.mirror_px, item_i.pixel) < sym_tol_i);

  assign edge_d   = edge_q + 18'(edge_v) + 18'(edge_h);
  assign corner_d = corner_q + 17'(corner_hit);
  assign match_d  = match_q + 16'(match_hit);
  assign pair_d   = pair_q + 16'(item_i.mirror_chk);

  assign width_x5  = 12'(width_i) * 12'd5;
  assign height_x6 = 12'(height_i) * 12'd6;

  // First rule that holds wins
  always_comb begin
    if (edge_d < EdgeFew && corner_d < CornerFew) begin
      label_d = LabelOne;
      conf_d  = ConfFewShape;
    end else if (edge_d > EdgeMany && corner_d > CornerMany) begin
      label_d = LabelEight;
      conf_d  = ConfBusy;
    end else if (width_x5 > height_x6) begin
      label_d = LabelOne;
      conf_d  = ConfWide;
    end else if ({match_d, 1'b0} > {1'b0, pair_d}) begin
      label_d = LabelZero;
      conf_d  = ConfSymmetric;
    end else begin
      label_d = LabelNone;
      conf_d  = ConfNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_left_q <= '0;
      left_q       <= '0;
      edge_q       <= '0;
      corner_q     <= '0;
      match_q      <= '0;
      pair_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (frame_clr_i) begin
        edge_q   <= '0;
        corner_q <= '0;
        match_q  <= '0;
        pair_q   <= '0;
      end else if (advance_o) begin
        upper_left_q <= item_i.above;
        left_q       <= item_i.pixel;
        edge_q       <= item_i.last ? '0 : edge_d;
        corner_q     <= item_i.last ? '0 : corner_d;
        match_q      <= item_i.last ? '0 : match_d;
        pair_q       <= item_i.last ? '0 : pair_d;
      end
      if (advance_o && item_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && item_i.last) begin
      label_q      <= label_d;
      conf_q       <= conf_d;
      edge_out_q   <= edge_d;
      corner_out_q <= corner_d;
      match_out_q  <= match_d;
      pair_out_q   <= pair_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign label_o             = label_q;
  assign confidence_tenths_o = conf_q;
  assign edge_count_o        = edge_out_q;
  assign corner_count_o      = corner_out_q;
  assign symmetry_matches_o  = match_out_q;
  assign pairs_checked_o     = pair_out_q;

endmodule

FILE: hw/rtl/digit_shape_feature_classifier.sv
// Throughput: one pixel word per cycle, except that a frame's last word waits while the
// previous result word is not yet taken; the two-read-port line buffer, read as a word is
// accepted, feeds one input register stage and one result register.
// Reset: configuration returns to 28x28, threshold 30, tolerance 20; counters and
// totals clear. The line buffer is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module digit_shape_feature_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dsfc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dsfc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [4:0]             label_o,
  output logic [3:0]                    confidence_tenths_o,
  output logic [17:0]                   edge_count_o,
  output logic [16:0]                   corner_count_o,
  output logic [15:0]                   symmetry_matches_o,
  output logic [15:0]                   pairs_checked_o
);
  import dsfc_pkg::*;

  // Configuration registers as written
  logic [DimW-1:0] width_q, height_q;
  logic [PixW-1:0] edge_thr_q, sym_tol_q;
  logic            frame_clr;

  // Dimensions as used: zero acts as one, anything above the maximum acts as it
  logic [DimW-1:0] width_eff, height_eff;

  logic             item_valid;
  dsfc_item_t       item;
  logic             advance;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [PixW-1:0]  ram_wdata, ram_rdata_a, ram_rdata_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= ResetWidth;
      height_q   <= ResetHeight;
      edge_thr_q <= ResetEdgeThr;
      sym_tol_q  <= ResetSymTol;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegImageWidth:   width_q    <= cfg_wdata_i;
        RegImageHeight:  height_q   <= cfg_wdata_i;
        RegEdgeThresh:   edge_thr_q <= cfg_wdata_i[PixW-1:0];
        RegSymTolerance: sym_tol_q  <= cfg_wdata_i[PixW-1:0];
        default: ;
      endcase
    end
  end

  // A dimension write restarts the frame; the line buffer keeps its contents
  assign frame_clr = cfg_we_i && (cfg_idx_i == RegImageWidth || cfg_idx_i == RegImageHeight);

  assign width_eff  = (width_q == '0) ? DimW'(1) :
                      (width_q > MaxWidthDim) ? MaxWidthDim : width_q;
  assign height_eff = (height_q == '0) ? DimW'(1) :
                      (height_q > MaxHeightDim) ? MaxHeightDim : height_q;

  // Position tracking, line buffer addressing, input register
  dsfc_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .width_i       (width_eff),
    .height_i      (height_eff),
    .frame_clr_i   (frame_clr),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_i       (pixel_i),
    .advance_i     (advance),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_a_o (ram_raddr_a),
    .ram_raddr_b_o (ram_raddr_b),
    .ram_rdata_a_i (ram_rdata_a),
    .ram_rdata_b_i (ram_rdata_b)
  );

  // Line buffer: row above at the current column, and this row's mirrored pixel
  dsfc_ram #(
    .WIDTH (PixW),
    .DEPTH (MaxWidth)
  ) u_line_buf (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (ram_re),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  // Totals, decision rules and the result register
  dsfc_accum u_accum (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .width_i             (width_eff),
    .height_i            (height_eff),
    .edge_thr_i          (edge_thr_q),
    .sym_tol_i           (sym_tol_q),
    .frame_clr_i         (frame_clr),
    .item_valid_i        (item_valid),
    .item_i              (item),
    .advance_o           (advance),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .label_o             (label_o),
    .confidence_tenths_o (confidence_tenths_o),
    .edge_count_o        (edge_count_o),
    .corner_count_o      (corner_count_o),
    .symmetry_matches_o  (symmetry_matches_o),
    .pairs_checked_o     (pairs_checked_o)
  );

endmodule
